// ----- rtl/core/key_matrix_debounce_scanner_unit_macros.svh -----
// ----------------------------------------------------------------------------
// key matrix debounce scanner assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while in reset
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_UNIT_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_UNIT_MACROS_SVH

// same-cycle implication
`define KMDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kmds_pkg.sv -----
// ----------------------------------------------------------------------------
// key matrix debounce scanner package
// request and result types, widths and the bit count helper
// ----------------------------------------------------------------------------
package kmds_pkg;

  localparam int COL_W = 14;
  localparam int CNT_W = 7;
  localparam int PC_W  = 4;
  localparam logic [7:0] RESET_PASSES = 8'd5;

  typedef struct packed {
    logic [2:0] row_index;
    logic [7:0] port_a_levels;
    logic [7:0] port_b_levels;
  } kmds_in_t;

  typedef struct packed {
    logic             settled;
    logic             committed;
    logic [COL_W-1:0] stable_row_bits;
    logic [CNT_W-1:0] pressed_count;
  } kmds_out_t;

  typedef struct packed {
    logic clear;
    logic add;
  } kmds_acc_ctl_t;

  // number of ones in one row word
  function automatic logic [PC_W-1:0] kmds_popcount(input logic [COL_W-1:0] w);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < COL_W; i++) begin
      n = n + PC_W'(w[i]);
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/kmds_pop_acc.sv -----
// ----------------------------------------------------------------------------
// kmds_pop_acc
// shared bit count accumulator, adds one row word per cycle while ctl.add is set
// ----------------------------------------------------------------------------
module kmds_pop_acc import kmds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  kmds_acc_ctl_t    ctl,
  input  logic [COL_W-1:0] word,
  output logic [CNT_W-1:0] sum_nxt
);

  logic [CNT_W-1:0] acc_r;

  assign sum_nxt = acc_r + CNT_W'(kmds_popcount(word));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.add) begin
      acc_r <= sum_nxt;
    end
  end

endmodule

// ----- rtl/core/key_matrix_debounce_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_unit
// row sample scanner with a global debounce countdown and a stable matrix
// ----------------------------------------------------------------------------
// sequence: an accepted request passes check, an optional commit walk, then done
// flow: one request at a time, taken again the cycle after its result is
//   loaded; a request waits in done while the previous result is not taken;
//   a commit walks the rows through one shared bit count adder
// reset: synchronous active-low rst_n clears both matrices, the pressed
//   count and the result valid; countdown and passes register load five
module key_matrix_debounce_scanner_unit import kmds_pkg::*; #(
  parameter int ROWS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration: debounce_passes
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  kmds_in_t   in_data,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output kmds_out_t  out_data
);

`include "key_matrix_debounce_scanner_unit_macros.svh"

  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // sequencer codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  kmds_in_t          req_r, req_nxt;
  logic [7:0]        passes_r;
  logic [7:0]        countdown_r, countdown_nxt;
  logic [CNT_W-1:0]  key_total_r, key_total_nxt;
  logic [ROW_AW-1:0] idx_r, idx_nxt;
  logic              committed_r, committed_nxt;
  logic              out_valid_r, out_valid_nxt;
  kmds_out_t         out_data_r, out_data_nxt;

  // row storage, one word per row
  logic [COL_W-1:0]  cand_r   [ROWS];
  logic [COL_W-1:0]  stable_r [ROWS];

  // request decode
  logic [COL_W-1:0]  cols;
  logic              row_ok;
  logic              row_last;
  logic [ROW_AW-1:0] row_idx;
  logic [ROW_AW-1:0] cand_addr;
  logic [COL_W-1:0]  cand_rd;
  logic              cand_we;
  logic              stable_we;
  logic [7:0]        reload;
  logic [7:0]        cd_a;
  logic [7:0]        cd_b;

  // shared bit count unit
  kmds_acc_ctl_t     acc_ctl;
  logic [CNT_W-1:0]  acc_sum_nxt;

  // invert active-low pins, port a on top, port b bits 7..2 below
  assign cols     = {~req_r.port_a_levels, ~req_r.port_b_levels[7:2]};
  assign row_ok   = ({1'b0, req_r.row_index} < 4'(ROWS));
  assign row_last = ({1'b0, req_r.row_index} == 4'(ROWS - 1));
  assign row_idx  = req_r.row_index[ROW_AW-1:0];

  // a zero passes setting counts as one
  assign reload   = (passes_r == 8'd0) ? 8'd1 : passes_r;

  // one read port on the candidate rows, commit walk or the sampled row
  assign cand_addr = (state_r == S_COMMIT) ? idx_r : row_idx;
  assign cand_rd   = cand_r[cand_addr];

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  kmds_pop_acc u_pop_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .word    (cand_rd),
    .sum_nxt (acc_sum_nxt)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    countdown_nxt = countdown_r;
    key_total_nxt = key_total_r;
    idx_nxt       = idx_r;
    committed_nxt = committed_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cand_we       = 1'b0;
    stable_we     = 1'b0;
    acc_ctl       = '0;
    cd_a          = countdown_r;
    cd_b          = countdown_r - 8'd1;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        committed_nxt = 1'b0;
        state_nxt     = S_DONE;
        if (row_ok) begin
          // changed sample restarts the debounce countdown
          if (cand_rd != cols) begin
            cand_we = 1'b1;
            cd_a    = reload;
          end
          countdown_nxt = cd_a;
          cd_b          = cd_a - 8'd1;
          // end of a pass ticks the countdown
          if (row_last && (cd_a != 8'd0)) begin
            countdown_nxt = cd_b;
            if (cd_b == 8'd0) begin
              idx_nxt       = '0;
              acc_ctl.clear = 1'b1;
              state_nxt     = S_COMMIT;
            end
          end
        end
      end

      S_COMMIT: begin
        // copy one candidate row into the stable matrix and count it
        stable_we   = 1'b1;
        acc_ctl.add = 1'b1;
        if (idx_r == ROW_AW'(ROWS - 1)) begin
          key_total_nxt = acc_sum_nxt;
          committed_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          idx_nxt = ROW_AW'(idx_r + 1'b1);
        end
      end

      S_DONE: begin
        // result register frees up once the previous result is taken
        if (!out_valid_r || out_ready) begin
          out_data_nxt.settled         = (countdown_r == 8'd0);
          out_data_nxt.committed       = committed_r;
          out_data_nxt.stable_row_bits = row_ok ? stable_r[row_idx] : '0;
          out_data_nxt.pressed_count   = key_total_r;
          out_valid_nxt                = 1'b1;
          state_nxt                    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      passes_r    <= RESET_PASSES;
      countdown_r <= RESET_PASSES;
      key_total_r <= '0;
      idx_r       <= '0;
      committed_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        cand_r[i]   <= '0;
        stable_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      countdown_r <= countdown_nxt;
      key_total_r <= key_total_nxt;
      idx_r       <= idx_nxt;
      committed_r <= committed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        passes_r <= cfg_wdata;
      end
      if (cand_we) begin
        cand_r[row_idx] <= cols;
      end
      if (stable_we) begin
        stable_r[idx_r] <= cand_rd;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `KMDS_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, state_r == S_CHECK, "request not checked after accept")
  `KMDS_ASSERT_NOW(a_commit_settled, out_valid_r && out_data_r.committed, out_data_r.settled, "commit reported while countdown nonzero")
  `KMDS_ASSERT_NOW(a_commit_idx, state_r == S_COMMIT, {1'b0, idx_r} < (ROW_AW + 1)'(ROWS), "commit walk past last row")
  `KMDS_ASSERT_NOW(a_count_bound, out_valid_r, out_data_r.pressed_count <= CNT_W'(ROWS * COL_W), "pressed count exceeds matrix size")

endmodule

// ----- verif/key_scan_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key scan checker
// watches the config port and both channels of the key matrix scanner, keeps
// its own copy of the debounce state, predicts one result per accepted
// request and compares every returned result field by field, in order
// ----------------------------------------------------------------------------
module key_scan_checker import kmds_pkg::*; #(
  parameter int ROWS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic      in_valid,
  input  logic      in_ready,
  input  kmds_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  kmds_out_t out_data,
  output int        fail_count,
  output int        scans_in_flight
);

  logic [COL_W-1:0] pending_rows [ROWS];
  logic [COL_W-1:0] settled_rows [ROWS];
  logic [7:0]       debounce_setting;
  logic [7:0]       pass_countdown;
  logic [CNT_W-1:0] pressed_total;
  kmds_out_t        expected_scans [$];

  initial begin
    fail_count = 0;
    scans_in_flight = 0;
  end

  // advance the shadow state by one row sample and return the result it gives
  function automatic kmds_out_t predict_scan(input kmds_in_t req);
    kmds_out_t        res;
    logic [COL_W-1:0] cols;
    int               idx;
    int               total;
    res  = '0;
    idx  = int'(req.row_index);
    cols = {~req.port_a_levels, ~req.port_b_levels[7:2]};
    if (idx < ROWS) begin
      if (pending_rows[idx] != cols) begin
        pending_rows[idx] = cols;
        pass_countdown = (debounce_setting == 8'd0) ? 8'd1 : debounce_setting;
      end
      if (idx == ROWS - 1 && pass_countdown != 8'd0) begin
        pass_countdown = pass_countdown - 8'd1;
        if (pass_countdown == 8'd0) begin
          total = 0;
          for (int i = 0; i < ROWS; i++) begin
            settled_rows[i] = pending_rows[i];
            total += $countones(settled_rows[i]);
          end
          pressed_total = CNT_W'(total);
          res.committed = 1'b1;
        end
      end
      res.stable_row_bits = settled_rows[idx];
    end
    res.settled = (pass_countdown == 8'd0);
    res.pressed_count = pressed_total;
    return res;
  endfunction

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    fail_count++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    kmds_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        pending_rows[i] = '0;
        settled_rows[i] = '0;
      end
      debounce_setting = RESET_PASSES;
      pass_countdown = RESET_PASSES;
      pressed_total = '0;
      expected_scans.delete();
    end else begin
      if (cfg_we) begin
        debounce_setting = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        expected_scans.push_back(predict_scan(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_scans.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request waiting, expected none, actual 0x%0h",
                   $time, out_data);
        end else begin
          want = expected_scans.pop_front();
          if (out_data.settled !== want.settled)
            flag_field("settled", want.settled, out_data.settled);
          if (out_data.committed !== want.committed)
            flag_field("committed", want.committed, out_data.committed);
          if (out_data.stable_row_bits !== want.stable_row_bits)
            flag_field("stable_row_bits", want.stable_row_bits, out_data.stable_row_bits);
          if (out_data.pressed_count !== want.pressed_count)
            flag_field("pressed_count", want.pressed_count, out_data.pressed_count);
        end
      end
    end
    scans_in_flight <= expected_scans.size();
  end

endmodule

// ----- verif/tb_key_matrix_debounce_scanner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key matrix debounce scanner testbench
// drives row samples through the scanner as whole scan passes with slowly
// changing, bouncing and random key patterns, steps the debounce setting
// through its extremes between phases, and leaves the checking to the
// scan checker that sits beside the block
// ----------------------------------------------------------------------------
module tb_key_matrix_debounce_scanner_unit;
  import kmds_pkg::*;

  localparam int ROWS = 8;
  localparam int PHASES = 10;
  localparam int PASSES_PER_PHASE = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 5000;

  // every block input starts at a known value
  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  kmds_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  kmds_out_t out_data;

  int fail_count;
  int scans_in_flight;

  // stimulus-side knobs read by the result sink
  bit no_gaps = 1'b0;
  bit hold_results = 1'b0;

  // intended raw port levels per row, active low
  logic [7:0] level_a [ROWS];
  logic [7:0] level_b [ROWS];

  key_matrix_debounce_scanner_unit #(.ROWS(ROWS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  key_scan_checker #(.ROWS(ROWS)) scan_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .scans_in_flight (scans_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one row sample; returns on the edge that accepts it
  // valid stays high across back-to-back requests, never dropped and raised in one step
  task automatic send_scan(input logic [2:0] row, input logic [7:0] pa, input logic [7:0] pb);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= kmds_in_t'{row_index: row, port_a_levels: pa, port_b_levels: pb};
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every predicted result to come back
  // the checker's in-flight count is registered, so look only after an edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (scans_in_flight != 0);
    // a commit ends before its result is loaded, so this wait is only margin
    repeat (ROWS + 3) @(posedge clk);
  endtask

  // debounce register is only written with the block idle
  task automatic write_passes(input logic [7:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one full scan pass over the intended levels; unused port b bits get noise
  task automatic scan_pass(input int last_row);
    for (int r = 0; r <= last_row; r++) begin
      send_scan(3'(r), level_a[r], {level_b[r][7:2], 2'($urandom)});
    end
  endtask

  // result side: random ready runs and stalls, plus one long hold on request
  initial begin : result_sink
    int run;
    int stall;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        // long hold, the block fills up and has to stall its request side
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        out_ready <= 1'b1;
        run = $urandom_range(1, 20);
        repeat (run) @(posedge clk);
        stall = idle_cycles();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] phase_passes [PHASES];
    bit         bounce_on;
    int         bounce_row;
    logic [7:0] bounce_a;
    logic [7:0] bounce_b;
    int         pick;
    int         row;
    int         bit_no;
    int         waited;

    phase_passes = '{8'd2, 8'd0, 8'd3, 8'd255, 8'd1, 8'd4, 8'd5, 8'd2, 8'd1, 8'd1};
    phase_passes[PHASES-1] = 8'($urandom_range(1, 8));
    bounce_on = 1'b0;
    bounce_row = 0;
    bounce_a = 8'hFF;
    bounce_b = 8'hFF;
    for (int r = 0; r < ROWS; r++) begin
      level_a[r] = 8'hFF;
      level_b[r] = 8'hFF;
    end

    // reset held at the start, released once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // fastest debounce so every pass that changes a row commits on the last row
    write_passes(8'd1);
    // every key pressed, the count reaches its top; port b low bits must not matter
    for (int r = 0; r < ROWS; r++) begin
      send_scan(3'(r), 8'h00, (r % 2 == 0) ? 8'h00 : 8'h03);
    end
    // every key released, count drops back to zero; again with the low bits toggled
    for (int r = 0; r < ROWS; r++) begin
      send_scan(3'(r), 8'hFF, (r % 2 == 0) ? 8'hFF : 8'hFC);
    end
    // walking single keys across both ports
    for (int r = 0; r < ROWS; r++) begin
      send_scan(3'(r), ~(8'h01 << r), ~(8'h04 << (r % 6)));
    end
    // rows out of order: the last row alone ends a pass
    send_scan(3'd7, 8'h00, 8'hFF);
    send_scan(3'd3, 8'hAA, 8'h55);
    send_scan(3'd0, 8'h5A, 8'hA5);

    // ---- random phases, one debounce setting each ----
    for (int p = 0; p < PHASES; p++) begin
      write_passes(phase_passes[p]);
      // one phase runs back to back while the result side holds off
      no_gaps = (p == 4);
      if (p == 4) hold_results = 1'b1;
      for (int n = 0; n < PASSES_PER_PHASE; n++) begin
        // mid-phase pause until every result is back
        if (p == 6 && n == PASSES_PER_PHASE / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // noise: random rows with random levels
          repeat ($urandom_range(1, 6)) begin
            send_scan(3'($urandom_range(0, ROWS - 1)), 8'($urandom), 8'($urandom));
          end
        end else begin
          // evolve the intended key pattern
          if (bounce_on) begin
            // bounce settles back to what it was
            level_a[bounce_row] = bounce_a;
            level_b[bounce_row] = bounce_b;
            bounce_on = 1'b0;
          end else begin
            pick = $urandom_range(0, 99);
            row = $urandom_range(0, ROWS - 1);
            bit_no = $urandom_range(0, COL_W - 1);
            if (pick < 40) begin
              // pattern held, lets the countdown run out
            end else if (pick < 65) begin
              // one key changes
              if (bit_no < 8) level_a[row][bit_no] = ~level_a[row][bit_no];
              else level_b[row][bit_no - 6] = ~level_b[row][bit_no - 6];
            end else if (pick < 78) begin
              // contact bounce for one pass
              bounce_on = 1'b1;
              bounce_row = row;
              bounce_a = level_a[row];
              bounce_b = level_b[row];
              if (bit_no < 8) level_a[row][bit_no] = ~level_a[row][bit_no];
              else level_b[row][bit_no - 6] = ~level_b[row][bit_no - 6];
            end else if (pick < 90) begin
              level_a[row] = 8'($urandom);
              level_b[row] = 8'($urandom);
            end else begin
              // whole matrix pressed or released
              for (int r = 0; r < ROWS; r++) begin
                level_a[r] = (pick < 95) ? 8'h00 : 8'hFF;
                level_b[r] = (pick < 95) ? 8'h00 : 8'hFF;
              end
            end
          end
          // a few passes are cut short before the last row
          if ($urandom_range(0, 99) < 6) scan_pass($urandom_range(0, ROWS - 2));
          else scan_pass(ROWS - 1);
        end
      end
      no_gaps = 1'b0;
    end

    // ---- wind down ----
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (scans_in_flight != 0 && waited < DRAIN_LIMIT);
    repeat (ROWS + 8) @(posedge clk);

    // leftover expectations count as a failure too
    if (fail_count == 0 && scans_in_flight == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
